>>> hw/rtl/ftrlp_pkg.sv
// Package with the request and result types and fixed constants of the FTRL-proximal block.
`timescale 1ns / 1ps
package ftrlp_pkg;

  localparam int CfgW = 31;
  localparam int IdxW = 10;
  localparam int QW = 32;
  localparam int DivNW = 48;
  localparam int DivDW = 32;
  localparam int SqrtRW = 48;

  localparam logic [2:0] RegAlpha = 3'd0;
  localparam logic [2:0] RegBeta = 3'd1;
  localparam logic [2:0] RegL1 = 3'd2;
  localparam logic [2:0] RegL2 = 3'd3;

  localparam logic [CfgW-1:0] AlphaReset = 31'd65536;
  localparam logic [CfgW-1:0] BetaReset = 31'd65536;
  localparam logic [CfgW-1:0] L1Reset = 31'd0;
  localparam logic [CfgW-1:0] L2Reset = 31'd65536;

  localparam logic [30:0] PosMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [IdxW-1:0]      coord_index;
    logic signed [QW-1:0] gradient;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0]      out_index;
    logic signed [QW-1:0] new_weight;
    logic                 sparse_zero;
    logic                 saturated;
  } out_t;

endpackage

>>> hw/rtl/ftrlp_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ftrlp_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);
  localparam int CW = $clog2(W + 1);

  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [W-1:0]   a_r;
  logic [2*W-1:0] p_r;
  logic [W:0]     sum;

  assign sum = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, a_r} : '0);
  assign done = busy_r && (cnt_r == '0);
  assign prod = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(W);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{W{1'b0}}, b};
    end else if (busy_r && (cnt_r != '0)) begin
      p_r <= {sum, p_r[W-1:1]};
    end
  end

endmodule

>>> hw/rtl/ftrlp_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module ftrlp_sqrt #(
  parameter int RW = 48
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);
  localparam int OW = RW / 2;
  localparam int CW = $clog2(OW + 1);

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [RW-1:0]   rad_r;
  logic [OW-1:0]   root_r;
  logic [OW+1:0]   rem_r;
  logic [OW+3:0]   trial_rem;
  logic [OW+3:0]   trial_sub;
  logic            fits;

  assign trial_rem = {rem_r, rad_r[RW-1:RW-2]};
  assign trial_sub = {2'b00, root_r, 2'b01};
  assign fits = trial_rem >= trial_sub;
  assign done = busy_r && (cnt_r == '0);
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(OW);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      root_r <= '0;
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rad_r <= {rad_r[RW-3:0], 2'b00};
      // The remainder stays below twice the root plus one, so it fits OW+2 bits.
      if (fits) begin
        rem_r <= (OW + 2)'(trial_rem - trial_sub);
        root_r <= {root_r[OW-2:0], 1'b1};
      end else begin
        rem_r <= (OW + 2)'(trial_rem);
        root_r <= {root_r[OW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/ftrlp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ftrlp_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits = trial >= {1'b0, div_r};
  assign done = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(NW);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r && (cnt_r != '0)) begin
      if (fits) rem_r <= DW'(trial - {1'b0, div_r});
      else rem_r <= DW'(trial);
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/ftrl_proximal_coordinate_update.sv
// Top level of the per-coordinate FTRL-proximal weight update.
//
// A request on in_valid/in_data names one coordinate and its summed gradient
// in signed Q16.16. The block reads that coordinate's weight, z and n, runs
// the update and returns one result on out_valid/out_data: the coordinate,
// the new weight and the sparse and saturation flags. The new state is
// written back when the result is issued.
// Requests are handled one at a time. The block is built around shared
// bit-serial units: a multiplier used twice, a square root used twice and a
// divider used up to three times; an item that ends sparse skips the last
// two divisions. Coordinates at or above FEATURES are first reduced by
// repeated subtraction, one subtraction per cycle.
// After reset the block clears its three stores, one entry per cycle, with
// in_stall high; configuration writes are taken at any time. A result waits
// in the output register while out_stall is high, and the next request is
// accepted and computed meanwhile; it holds before its write-back until the
// output register is free.
`timescale 1ns / 1ps
module ftrl_proximal_coordinate_update #(
  parameter int FEATURES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ftrlp_pkg::in_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ftrlp_pkg::out_t       out_data,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_index,
  input  logic [ftrlp_pkg::CfgW-1:0] cfg_data
);
  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RED = 4'd2;
  localparam logic [3:0] S_CAP = 4'd3;
  localparam logic [3:0] S_G2 = 4'd4;
  localparam logic [3:0] S_SQ1 = 4'd5;
  localparam logic [3:0] S_SQ2 = 4'd6;
  localparam logic [3:0] S_DV1 = 4'd7;
  localparam logic [3:0] S_M2 = 4'd8;
  localparam logic [3:0] S_DV2 = 4'd9;
  localparam logic [3:0] S_DV3 = 4'd10;
  localparam logic [3:0] S_WB = 4'd11;

  logic [3:0]  state_r;
  logic [AW-1:0] clr_cnt_r;

  logic [30:0] alpha_r, beta_r, l1_r, l2_r;

  logic [9:0]         idx_r;
  logic signed [31:0] g_r;
  logic signed [31:0] w_old_r, z_old_r, z_new_r;
  logic [30:0]        n_old_r, n_new_r;
  logic [23:0]        sq_old_r, sq_new_r;
  logic [47:0]        q_r;
  logic               sat_r, sparse_r;

  logic               out_valid_r;
  ftrlp_pkg::out_t    out_data_r;

  // Stores and their registered read data.
  logic [31:0] w_mem [FEATURES];
  logic [31:0] z_mem [FEATURES];
  logic [31:0] n_mem [FEATURES];
  logic [31:0] w_rd_r, z_rd_r, n_rd_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [31:0]   w_wr, z_wr, n_wr;

  // Arithmetic units.
  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic        sqrt_start, sqrt_done;
  logic [47:0] sqrt_rad;
  logic [23:0] sqrt_root;
  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic [31:0] div_den;

  logic [30:0] alpha_eff;
  logic [31:0] gmag, wmag, zmag;
  logic [47:0] g2_full;
  logic [31:0] n_sum;
  logic [45:0] sw_mag;
  logic signed [47:0] sw, z_sum;
  logic signed [31:0] z_clamp;
  logic        z_over;
  logic [31:0] num;
  logic [48:0] den_sum;
  logic [30:0] den;
  logic        den_over;
  logic signed [31:0] w_new;
  logic        w_over;
  logic        out_free;

  assign alpha_eff = (alpha_r == '0) ? 31'd1 : alpha_r;
  assign gmag = g_r[31] ? 32'(-g_r) : 32'(g_r);
  assign wmag = w_old_r[31] ? 32'(-w_old_r) : 32'(w_old_r);
  assign zmag = z_new_r[31] ? 32'(-z_new_r) : 32'(z_new_r);
  assign num = zmag - {1'b0, l1_r};
  assign out_free = !(out_valid_r && out_stall);

  assign g2_full = mul_prod[63:16];
  assign sw_mag = mul_prod[61:16];
  assign sw = w_old_r[31] ? -$signed({2'b00, sw_mag}) : $signed({2'b00, sw_mag});
  assign z_sum = 48'(z_old_r) + 48'(g_r) - sw;
  assign z_over = (z_sum > 48'sh0000_7FFF_FFFF) || (z_sum < -48'sh0000_8000_0000);
  assign z_clamp = (z_sum > 48'sh0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (z_sum < -48'sh0000_8000_0000) ? 32'sh8000_0000 : 32'(z_sum);
  assign den_sum = {1'b0, div_quo} + 49'(l2_r);
  assign den_over = den_sum > 49'(ftrlp_pkg::PosMax);
  assign den = den_over ? ftrlp_pkg::PosMax : 31'(den_sum);

  // Weight from the final quotient, sign opposite to z.
  always_comb begin
    w_new = '0;
    w_over = 1'b0;
    if (!sparse_r) begin
      if (!z_new_r[31]) begin
        w_over = q_r > 48'h0000_8000_0000;
        w_new = w_over ? 32'sh8000_0000 : 32'(-$signed({1'b0, q_r}));
      end else begin
        w_over = q_r > 48'h0000_7FFF_FFFF;
        w_new = w_over ? 32'sh7FFF_FFFF : 32'(q_r);
      end
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = gmag;
    mul_b = gmag;
    sqrt_start = 1'b0;
    sqrt_rad = {1'b0, n_old_r, 16'b0};
    div_start = 1'b0;
    div_num = 48'({24'(sqrt_root - sq_old_r), 16'b0});
    div_den = {1'b0, alpha_eff};
    case (state_r)
      S_CAP: mul_start = 1'b1;
      S_G2: sqrt_start = mul_done;
      S_SQ1: begin
        sqrt_start = sqrt_done;
        sqrt_rad = {1'b0, n_new_r, 16'b0};
      end
      S_SQ2: div_start = sqrt_done;
      S_DV1: begin
        mul_start = div_done;
        mul_a = (div_quo > 48'(ftrlp_pkg::PosMax)) ? {1'b0, ftrlp_pkg::PosMax}
                                                    : 32'(div_quo);
        mul_b = wmag;
      end
      S_M2: begin
        div_start = mul_done && ({1'b0, (z_clamp[31] ? 32'(-z_clamp) : 32'(z_clamp))}
                                 > {2'b00, l1_r});
        div_num = {32'({1'b0, beta_r} + {8'b0, sq_new_r}), 16'b0};
      end
      S_DV2: begin
        div_start = div_done && (den != '0);
        div_num = {num, 16'b0};
        div_den = {1'b0, den};
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_addr = AW'(idx_r);
    mem_we = 1'b0;
    w_wr = 32'(w_new);
    z_wr = 32'(z_new_r);
    n_wr = {1'b0, n_new_r};
    if (state_r == S_CLR) begin
      mem_addr = clr_cnt_r;
      mem_we = 1'b1;
      w_wr = '0;
      z_wr = '0;
      n_wr = '0;
    end else if (state_r == S_WB && out_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      w_mem[mem_addr] <= w_wr;
      z_mem[mem_addr] <= z_wr;
      n_mem[mem_addr] <= n_wr;
    end
    w_rd_r <= w_mem[mem_addr];
    z_rd_r <= z_mem[mem_addr];
    n_rd_r <= n_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ftrlp_pkg::AlphaReset;
      beta_r <= ftrlp_pkg::BetaReset;
      l1_r <= ftrlp_pkg::L1Reset;
      l2_r <= ftrlp_pkg::L2Reset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ftrlp_pkg::RegAlpha: alpha_r <= cfg_data;
        ftrlp_pkg::RegBeta: beta_r <= cfg_data;
        ftrlp_pkg::RegL1: l1_r <= cfg_data;
        ftrlp_pkg::RegL2: l2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(FEATURES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) state_r <= S_RED;
        S_RED: if (32'(idx_r) < 32'(FEATURES)) state_r <= S_CAP;
        S_CAP: state_r <= S_G2;
        S_G2: if (mul_done) state_r <= S_SQ1;
        S_SQ1: if (sqrt_done) state_r <= S_SQ2;
        S_SQ2: if (sqrt_done) state_r <= S_DV1;
        S_DV1: if (div_done) state_r <= S_M2;
        S_M2: if (mul_done) state_r <= div_start ? S_DV2 : S_WB;
        S_DV2: if (div_done) state_r <= div_start ? S_DV3 : S_WB;
        S_DV3: if (div_done) state_r <= S_WB;
        S_WB: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        idx_r <= in_data.coord_index;
        g_r <= in_data.gradient;
        sat_r <= 1'b0;
        sparse_r <= 1'b0;
      end
      S_RED: if (32'(idx_r) >= 32'(FEATURES)) idx_r <= idx_r - 10'(FEATURES);
      S_CAP: begin
        w_old_r <= $signed(w_rd_r);
        z_old_r <= $signed(z_rd_r);
        n_old_r <= n_rd_r[30:0];
      end
      S_G2: begin
        if (mul_done) begin
          if (g2_full > 48'(ftrlp_pkg::PosMax)) sat_r <= 1'b1;
          if (n_sum > 32'(ftrlp_pkg::PosMax)) sat_r <= 1'b1;
          n_new_r <= (n_sum > 32'(ftrlp_pkg::PosMax)) ? ftrlp_pkg::PosMax : 31'(n_sum);
        end
      end
      S_SQ1: if (sqrt_done) sq_old_r <= sqrt_root;
      S_SQ2: if (sqrt_done) sq_new_r <= sqrt_root;
      S_DV1: if (div_done && (div_quo > 48'(ftrlp_pkg::PosMax))) sat_r <= 1'b1;
      S_M2: begin
        if (mul_done) begin
          z_new_r <= z_clamp;
          if (z_over) sat_r <= 1'b1;
          sparse_r <= !div_start;
        end
      end
      S_DV2: begin
        if (div_done) begin
          if (den_over) sat_r <= 1'b1;
          if (den == '0) begin
            sat_r <= 1'b1;
            q_r <= 48'h0000_8000_0000;
          end
        end
      end
      S_DV3: if (div_done) q_r <= div_quo;
      S_WB: begin
        if (out_free) begin
          out_data_r.out_index <= idx_r;
          out_data_r.new_weight <= w_new;
          out_data_r.sparse_zero <= sparse_r;
          out_data_r.saturated <= sat_r | w_over;
        end
      end
      default: ;
    endcase
  end

  // Clamped g*g added to the old sum; both fit 31 bits once clamped.
  assign n_sum = {1'b0, n_old_r} +
                 ((g2_full > 48'(ftrlp_pkg::PosMax)) ? {1'b0, ftrlp_pkg::PosMax}
                                                      : 32'(g2_full));

  ftrlp_mul #(.W(32)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  ftrlp_sqrt #(.RW(ftrlp_pkg::SqrtRW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sqrt_rad),
    .done(sqrt_done), .root(sqrt_root)
  );

  ftrlp_div #(.NW(ftrlp_pkg::DivNW), .DW(ftrlp_pkg::DivDW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_quo)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> test/ftrl_proximal_coordinate_update_test.sv
// Self-checking testbench for the per-coordinate FTRL-proximal weight update.
`timescale 1ns / 1ps
module ftrl_proximal_coordinate_update_test;

  localparam int Features = 1024;
  localparam int CycleLimit = 1500000;
  localparam int HoldCycles = 1500;
  localparam int SettleCycles = 400;
  localparam longint unsigned PosLimit = 64'h7FFF_FFFF;
  localparam longint SignedMax = 64'sh7FFF_FFFF;
  localparam longint SignedMin = -64'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ftrlp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ftrlp_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [ftrlp_pkg::CfgW-1:0] cfg_data = '0;

  ftrl_proximal_coordinate_update #(.FEATURES(Features)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted per-coordinate state and register copies.
  logic signed [31:0] weight_mem [Features];
  logic signed [31:0] z_mem [Features];
  logic [30:0] n_mem [Features];
  longint unsigned alpha_reg = 65536, beta_reg = 65536, l1_reg = 0, l2_reg = 65536;

  ftrlp_pkg::out_t pending_weights [$];
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int sparse_seen = 0;
  int saturated_seen = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ftrlp_pkg::out_t ftrl_update(ftrlp_pkg::in_t r);
    ftrlp_pkg::out_t o;
    int k;
    longint g, w_old, z, sw, w_new;
    longint unsigned alpha, n_old, gmag, g2, n_new, sq_old, sq_new, sigma;
    longint unsigned wmag, prod, zmag, num, den, q;
    bit sat, sparse;
    sat = 1'b0;
    sparse = 1'b0;
    k = int'(r.coord_index) % Features;
    g = $signed(r.gradient);
    alpha = (alpha_reg == 0) ? 1 : alpha_reg;
    w_old = weight_mem[k];
    z = z_mem[k];
    n_old = n_mem[k];
    gmag = (g < 0) ? -g : g;
    g2 = (gmag * gmag) >> 16;
    if (g2 > PosLimit) begin g2 = PosLimit; sat = 1'b1; end
    n_new = n_old + g2;
    if (n_new > PosLimit) begin n_new = PosLimit; sat = 1'b1; end
    sq_old = int_sqrt(n_old << 16);
    sq_new = int_sqrt(n_new << 16);
    sigma = ((sq_new - sq_old) << 16) / alpha;
    if (sigma > PosLimit) begin sigma = PosLimit; sat = 1'b1; end
    wmag = (w_old < 0) ? -w_old : w_old;
    prod = (sigma * wmag) >> 16;
    sw = (w_old < 0) ? -longint'(prod) : longint'(prod);
    z = z + g - sw;
    if (z > SignedMax) begin z = SignedMax; sat = 1'b1; end
    if (z < SignedMin) begin z = SignedMin; sat = 1'b1; end
    zmag = (z < 0) ? -z : z;
    if (zmag <= l1_reg) begin
      sparse = 1'b1;
      w_new = 0;
    end else begin
      num = zmag - l1_reg;
      den = ((beta_reg + sq_new) << 16) / alpha + l2_reg;
      if (den > PosLimit) begin den = PosLimit; sat = 1'b1; end
      // With no denominator the weight goes to full scale against z.
      if (den == 0) begin
        sat = 1'b1;
        q = 64'h8000_0000;
      end else begin
        q = (num << 16) / den;
      end
      w_new = (z > 0) ? -longint'(q) : longint'(q);
      if (w_new > SignedMax) begin w_new = SignedMax; sat = 1'b1; end
      if (w_new < SignedMin) begin w_new = SignedMin; sat = 1'b1; end
    end
    weight_mem[k] = w_new[31:0];
    z_mem[k] = z[31:0];
    n_mem[k] = n_new[30:0];
    o.out_index = k[ftrlp_pkg::IdxW-1:0];
    o.new_weight = w_new[31:0];
    o.sparse_zero = sparse;
    o.saturated = sat;
    return o;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    ftrlp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_weights.pop_front();
        sparse_seen += want.sparse_zero;
        saturated_seen += want.saturated;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: index %0d/%0d weight %h/%h sparse %b/%b sat %b/%b (exp/got)",
                     want.out_index, out_data.out_index, want.new_weight,
                     out_data.new_weight, want.sparse_zero, out_data.sparse_zero,
                     want.saturated, out_data.saturated);
        end
      end
    end
  end

  // Result-side stall: random, or a long hold when a test asks for one.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [ftrlp_pkg::IdxW-1:0] idx, logic signed [31:0] grad);
    ftrlp_pkg::in_t r;
    r.coord_index = idx;
    r.gradient = grad;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_weights.push_back(ftrl_update(r));
    requests_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ftrlp_pkg::CfgW-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      ftrlp_pkg::RegAlpha: alpha_reg = val[ftrlp_pkg::CfgW-1:0];
      ftrlp_pkg::RegBeta:  beta_reg = val[ftrlp_pkg::CfgW-1:0];
      ftrlp_pkg::RegL1:    l1_reg = val[ftrlp_pkg::CfgW-1:0];
      ftrlp_pkg::RegL2:    l2_reg = val[ftrlp_pkg::CfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_params(longint unsigned a, longint unsigned b,
                            longint unsigned l1, longint unsigned l2);
    write_reg(ftrlp_pkg::RegAlpha, a);
    write_reg(ftrlp_pkg::RegBeta, b);
    write_reg(ftrlp_pkg::RegL1, l1);
    write_reg(ftrlp_pkg::RegL2, l2);
  endtask

  function automatic logic signed [31:0] rand_gradient();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return $signed($urandom_range(511)) - 256;
    if (pick < 50) return $signed($urandom_range(131071)) - 65536;
    if (pick < 80) return $signed($urandom_range(2097151)) - 1048576;
    if (pick < 95) return $urandom;
    return ($urandom_range(1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  task automatic test_directed_extremes();
    send_request(10'd0, 32'sd0);
    send_request(10'd0, 32'sd65536);
    send_request(10'd0, -32'sd65536);
    send_request(10'd1023, 32'sh7FFF_FFFF);
    send_request(10'd1023, 32'sh7FFF_FFFF);
    send_request(10'd1022, 32'sh8000_0000);
    send_request(10'd1022, -32'sd1);
    send_request(10'd512, 32'sh5555_5555);
    send_request(10'd341, 32'shAAAA_AAAA);
  endtask

  task automatic test_register_corners();
    // A zero rate is taken as one LSB.
    write_reg(ftrlp_pkg::RegAlpha, 0);
    send_request(10'd2, 32'sd98304);
    send_request(10'd2, -32'sd40000);
    set_params(PosLimit, PosLimit, 65536, PosLimit);
    send_request(10'd3, 32'sd1000000);
    send_request(10'd3, -32'sd12345);
    // Large L1 threshold forces sparse weights.
    set_params(65536, 65536, PosLimit, 0);
    send_request(10'd4, 32'sh7FFF_FFFF);
    send_request(10'd4, 32'sh8000_0000);
    // Denominator of zero on untouched coordinates, both signs of z.
    set_params(65536, 0, 0, 0);
    send_request(10'd600, 32'sd100);
    send_request(10'd601, -32'sd100);
    // Writes to registers past the last one must leave the others alone.
    write_reg(3'd4, PosLimit);
    write_reg(3'd5, 0);
    write_reg(3'd6, 12345);
    write_reg(3'd7, PosLimit);
    send_request(10'd602, 32'sd200);
    set_params(65536, 65536, 0, 65536);
  endtask

  task automatic random_phase(int count);
    logic [ftrlp_pkg::IdxW-1:0] base;
    logic [ftrlp_pkg::IdxW-1:0] idx;
    base = 10'($urandom);
    repeat (count) begin
      // Mostly revisit a few coordinates so the stored state builds up.
      if ($urandom_range(99) < 60) idx = base + 10'($urandom_range(7));
      else idx = 10'($urandom);
      send_request(idx, rand_gradient());
    end
  endtask

  task automatic test_random_settings();
    random_phase(150);
    set_params(32768, 0, 16384, 0);
    random_phase(150);
    steady = 1'b1;
    set_params(PosLimit, PosLimit, 0, 0);
    random_phase(120);
    steady = 1'b0;
    set_params(1, 1, 1, 1);
    random_phase(120);
    set_params(262144, 131072, 65536, 32768);
    random_phase(150);
  endtask

  task automatic test_output_hold();
    hold_req = 1'b1;
    repeat (8) send_request(10'($urandom), rand_gradient());
    drain();
  endtask

  task automatic test_pause_then_resume();
    random_phase(20);
    drain();
    random_phase(20);
  endtask

  initial begin
    for (int i = 0; i < Features; i++) begin
      weight_mem[i] = '0;
      z_mem[i] = '0;
      n_mem[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_register_corners();
    test_output_hold();
    test_random_settings();
    test_pause_then_resume();
    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d requests across many register settings and stall patterns;",
             requests_sent);
    $display("%0d results, %0d sparse, %0d saturated.",
             results_seen, sparse_seen, saturated_seen);
    $display("Mismatches: %0d, results still owed: %0d.", mismatches, pending_weights.size());
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ftrlp_pkg.sv
hw/rtl/ftrlp_mul.sv
hw/rtl/ftrlp_sqrt.sv
hw/rtl/ftrlp_div.sv
hw/rtl/ftrl_proximal_coordinate_update.sv
test/ftrl_proximal_coordinate_update_test.sv
